/* rtl/tmfi_pkg.sv */
// Shared types, constants and the reading decode for the fan integrator.
// Used by tmfi_track, tmfi_loop and temperature_max_fan_integrator.
package tmfi_pkg;

  // Number of sensors; the last index is the local board sensor.
  localparam int NumSensors = 8;
  // Fan level to duty right shift.
  localparam int DutyShift = 2;

  localparam int TempW  = 10;  // half-degree temperatures and errors
  localparam int TargW  = 9;
  localparam int LevelW = 10;
  localparam int DutyW  = 8;
  localparam int IdxW   = 3;
  localparam int CfgW   = 10;

  localparam logic [LevelW-1:0] LevelReset    = 10'd400;
  localparam logic [LevelW-1:0] MaxLevelReset = 10'd400;
  localparam logic signed [TargW-1:0] TargetReset = 9'sd54;
  localparam logic signed [TempW-1:0] LocalReset  = 10'sd44;

  // Item op codes
  localparam logic OpReading = 1'b0;
  localparam logic OpTick    = 1'b1;

  // Configuration register indexes
  localparam logic CfgTarget   = 1'b0;
  localparam logic CfgMaxLevel = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [IdxW-1:0]         idx;
    logic signed [7:0]       whole;
    logic                    half;
    logic                    err;
  } item_t;

  typedef struct packed {
    logic  fire;   // input register advances this cycle
    item_t item;
  } step_t;

  // Whole degrees plus half flag to half degrees, range -257..255.
  function automatic logic signed [TempW-1:0] decode_half(
    input logic signed [7:0] whole,
    input logic              half
  );
    logic signed [TempW-1:0] t;
    t = {whole[7], whole, 1'b0};
    if (half && !whole[7] && (whole != 8'sd0)) begin
      t = t + 10'sd1;
    end else if (!half && whole[7]) begin
      t = t - 10'sd1;
    end
    return t;
  endfunction

endpackage

/* rtl/temperature_max_fan_integrator.sv */
// Top level of the max-temperature fan integrator: input register, config
// registers, tracker and integrator. Depends on tmfi_pkg, tmfi_track, tmfi_loop.
//
// Accepts one item per clock while in_stall_o is low. A reading updates the round
// maximum (remote sensors) or the local temperature (last sensor) in the cycle
// after its transfer; an end-of-round tick loads its result from the input
// register into the output register once that register is free, and the result
// is held there until taken. in_stall_o rises only while a tick sits in the
// input register and the output register still holds an untaken result, so
// the single output register sets the rate under back pressure.
// Configuration writes take effect at the next edge.
module temperature_max_fan_integrator import tmfi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic [IdxW-1:0]         sensor_index_i,
  input  logic signed [7:0]       temp_whole_i,
  input  logic                    half_bit_i,
  input  logic                    read_error_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DutyW-1:0]        fan_duty_o,
  output logic                    fan_off_o,
  output logic signed [TempW-1:0] used_temp_half_o,
  output logic signed [TempW-1:0] temp_error_half_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i
);

  item_t                   s1_item_q;
  logic                    s1_valid_q, s1_valid_d;
  logic signed [TargW-1:0] target_q;
  logic [LevelW-1:0]       max_level_q;
  logic                    in_xfer, s1_fire, tick_fire, out_take;
  step_t                   step;
  logic signed [TempW-1:0] used_half;

  assign out_take   = out_valid_o & ~out_stall_i;
  // Hold a tick while the output register is still occupied.
  assign in_stall_o = s1_valid_q & (s1_item_q.op == OpTick) & out_valid_o & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign s1_fire    = s1_valid_q & ~in_stall_o;
  assign tick_fire  = s1_fire & (s1_item_q.op == OpTick);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      target_q    <= TargetReset;
      max_level_q <= MaxLevelReset;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgTarget:   target_q    <= cfg_data_i[TargW-1:0];
          CfgMaxLevel: max_level_q <= cfg_data_i[LevelW-1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.op    <= op_i;
      s1_item_q.idx   <= sensor_index_i;
      s1_item_q.whole <= temp_whole_i;
      s1_item_q.half  <= half_bit_i;
      s1_item_q.err   <= read_error_i;
    end
  end

  assign step = {s1_fire, s1_item_q};

  tmfi_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .used_half_o (used_half)
  );

  tmfi_loop u_loop (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_fire),
    .out_take_i  (out_take),
    .used_half_i (used_half),
    .target_i    (target_q),
    .max_level_i (max_level_q),
    .out_valid_o (out_valid_o),
    .fan_duty_o  (fan_duty_o),
    .fan_off_o   (fan_off_o),
    .used_half_o (used_temp_half_o),
    .err_half_o  (temp_error_half_o)
  );

  // A tick never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |-> !(out_valid_o && out_stall_i))
    else $error("tick loaded over a pending result");

  // A new result appears only after a tick left the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tick_fire))
    else $error("result without a tick");

  // Stall only with a tick held in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_item_q.op == OpTick))
    else $error("stall without a held tick");

  // Fan-off flag tracks the duty of the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fan_off_o == (fan_duty_o == '0)))
    else $error("fan_off disagrees with duty");

  // Reported temperature stays within the decode range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (used_temp_half_o >= -10'sd257 && used_temp_half_o <= 10'sd255))
    else $error("used temperature out of range");

endmodule

/* rtl/tmfi_track.sv */
// Round maximum of remote readings and the stored local temperature.
// Depends on tmfi_pkg.
module tmfi_track import tmfi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  step_t                   step_i,
  output logic signed [TempW-1:0] used_half_o
);

  localparam logic [4:0] LastIdx = 5'(NumSensors - 1);

  logic signed [TempW-1:0] round_max_q, round_max_d;
  logic                    max_valid_q, max_valid_d;
  logic signed [TempW-1:0] local_q, local_d;
  logic signed [TempW-1:0] temp_half;
  logic [4:0]              idx_ext;

  assign temp_half = decode_half(step_i.item.whole, step_i.item.half);
  assign idx_ext   = 5'(step_i.item.idx);

  always_comb begin
    round_max_d = round_max_q;
    max_valid_d = max_valid_q;
    local_d     = local_q;
    if (step_i.fire) begin
      if (step_i.item.op == OpTick) begin
        max_valid_d = 1'b0;
      end else if (!step_i.item.err) begin
        if (idx_ext < LastIdx) begin
          if (!max_valid_q || (temp_half > round_max_q)) begin
            round_max_d = temp_half;
            max_valid_d = 1'b1;
          end
        end else if (idx_ext == LastIdx) begin
          local_d = temp_half;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_max_q <= '0;
      max_valid_q <= 1'b0;
      local_q     <= LocalReset;
    end else begin
      round_max_q <= round_max_d;
      max_valid_q <= max_valid_d;
      local_q     <= local_d;
    end
  end

  // Fall back to the local sensor when no remote sensor reported this round.
  assign used_half_o = max_valid_q ? round_max_q : local_q;

endmodule

/* rtl/tmfi_loop.sv */
// Integrator, clamp and duty mapping, with the result register.
// Depends on tmfi_pkg.
module tmfi_loop import tmfi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_i,
  input  logic                    out_take_i,
  input  logic signed [TempW-1:0] used_half_i,
  input  logic signed [TargW-1:0] target_i,
  input  logic [LevelW-1:0]       max_level_i,
  output logic                    out_valid_o,
  output logic [DutyW-1:0]        fan_duty_o,
  output logic                    fan_off_o,
  output logic signed [TempW-1:0] used_half_o,
  output logic signed [TempW-1:0] err_half_o
);

  localparam int SumW = LevelW + 2;

  logic [LevelW-1:0]       level_q, level_d;
  logic                    out_valid_q, out_valid_d;
  logic [DutyW-1:0]        duty_q;
  logic                    off_q;
  logic signed [TempW-1:0] used_q, err_q;

  logic signed [TempW-1:0] err_half;
  logic signed [SumW-1:0]  sum;
  logic [LevelW-1:0]       shifted;
  logic [DutyW-1:0]        duty;

  assign err_half = used_half_i - TempW'(target_i);
  assign sum      = $signed({2'b00, level_q}) + SumW'(err_half);

  always_comb begin
    if (sum < 0) begin
      level_d = '0;
    end else if (sum > $signed({2'b00, max_level_i})) begin
      level_d = max_level_i;
    end else begin
      level_d = sum[LevelW-1:0];
    end
  end

  assign shifted = level_d >> DutyShift;
  assign duty    = (shifted > LevelW'(255)) ? 8'd255 : shifted[DutyW-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_i) begin
      out_valid_d = 1'b1;
    end else if (out_take_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LevelReset;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_i) begin
        level_q <= level_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load on a tick only.
  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      duty_q <= duty;
      off_q  <= (duty == '0);
      used_q <= used_half_i;
      err_q  <= err_half;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fan_duty_o  = duty_q;
  assign fan_off_o   = off_q;
  assign used_half_o = used_q;
  assign err_half_o  = err_q;

endmodule
